// ----- design/eafr_pkg.sv -----
// types and constants shared by the escaped api frame receiver
`default_nettype none

package eafr_pkg;

  localparam int unsigned LEN_W = 7;

  localparam logic [7:0] START_BYTE = 8'h7E;
  localparam logic [7:0] ESC_BYTE   = 8'h7D;
  localparam logic [7:0] ESC_XOR    = 8'h20;
  localparam logic [7:0] CR_BYTE    = 8'h0D;
  localparam logic [7:0] API_RX16   = 8'h81;
  localparam logic [7:0] API_TXSTAT = 8'h89;
  localparam logic [7:0] SUM_OK     = 8'hFF;

  localparam logic [LEN_W-1:0] RX_HDR_LEN = LEN_W'(5);

  typedef enum logic [1:0] {
    KIND_CHAR      = 2'd0,
    KIND_LINE_END  = 2'd1,
    KIND_DATA      = 2'd2,
    KIND_FRAME_END = 2'd3
  } eafr_kind_e;

  typedef enum logic [1:0] {
    STAT_OK      = 2'd0,
    STAT_BAD_SUM = 2'd1,
    STAT_BAD_API = 2'd2
  } eafr_status_e;

  typedef enum logic [3:0] {
    PH_HUNT = 4'b0001,
    PH_LEN  = 4'b0010,
    PH_PAY  = 4'b0100,
    PH_SUM  = 4'b1000
  } eafr_phase_e;

  typedef struct packed {
    eafr_kind_e       kind;
    logic [7:0]       data_byte;
    eafr_status_e     frame_status;
    logic [7:0]       api_id;
    logic [15:0]      source_address;
    logic [7:0]       signal_strength;
    logic [7:0]       rx_options;
    logic [7:0]       tx_frame_id;
    logic [7:0]       tx_status;
    logic [LEN_W-1:0] data_count;
  } eafr_result_t;

endpackage

`default_nettype wire

// ----- design/eafr_in_if.sv -----
// input channel: one received serial byte per word
`default_nettype none

interface eafr_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink (input valid, input rx_byte, output ready);
endinterface

`default_nettype wire

// ----- design/eafr_out_if.sv -----
// output channel: one decoded result per word
`default_nettype none

interface eafr_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic [7:0]  data_byte;
  logic [1:0]  frame_status;
  logic [7:0]  api_id;
  logic [15:0] source_address;
  logic [7:0]  signal_strength;
  logic [7:0]  rx_options;
  logic [7:0]  tx_frame_id;
  logic [7:0]  tx_status;
  logic [6:0]  data_count;

  modport source (
    output valid, output kind, output data_byte, output frame_status, output api_id,
    output source_address, output signal_strength, output rx_options,
    output tx_frame_id, output tx_status, output data_count, input ready
  );
  modport sink (
    input valid, input kind, input data_byte, input frame_status, input api_id,
    input source_address, input signal_strength, input rx_options,
    input tx_frame_id, input tx_status, input data_count, output ready
  );
endinterface

`default_nettype wire

// ----- design/escaped_api_frame_receiver_top.sv -----
// escaped api frame receiver top level: input register, parser, result register
//
// channel   dir  handshake     word
// rx_i      in   valid/ready   rx_byte
// res_o     out  valid/ready   kind, data_byte, frame_status, header fields, data_count
// cfg       in   cfg_we_i      cfg_wdata_i = line_mode
//
// one byte per cycle sustained while results are taken; a byte waits in the input register
// and its result, if any, is loaded into the result register as the byte leaves it
// the parser state updates when a byte leaves the input register
// a held result stalls both stages; the input register still fills while empty
// reset puts the receiver in line mode, hunting for a start byte
`default_nettype none

module escaped_api_frame_receiver_top
  import eafr_pkg::*;
#(
  parameter int unsigned LINE_CHARS    = 30,
  parameter int unsigned MAX_FRAME_LEN = 126
) (
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  input  wire logic   cfg_we_i,
  input  wire logic   cfg_wdata_i,
  eafr_in_if.sink     rx_i,
  eafr_out_if.source  res_o
);

  logic         line_mode_q;
  logic         in_valid_q;
  logic [7:0]   in_byte_q;
  logic         out_valid_q;
  eafr_result_t out_q;
  eafr_result_t core_res;
  logic         core_valid;
  logic         advance;
  logic         step;

  assign advance  = !out_valid_q || res_o.ready;
  assign step     = in_valid_q && advance;
  assign rx_i.ready = !in_valid_q || advance;

  eafr_core #(
    .LINE_CHARS    (LINE_CHARS),
    .MAX_FRAME_LEN (MAX_FRAME_LEN)
  ) u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .step_i      (step),
    .rx_byte_i   (in_byte_q),
    .line_mode_i (line_mode_q),
    .res_o       (core_res),
    .res_valid_o (core_valid)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      line_mode_q <= 1'b1;
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        line_mode_q <= cfg_wdata_i;
      end
      if (rx_i.ready) begin
        in_valid_q <= rx_i.valid;
      end
      if (advance) begin
        out_valid_q <= step && core_valid;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (rx_i.valid && rx_i.ready) begin
      in_byte_q <= rx_i.rx_byte;
    end
    if (step && core_valid) begin
      out_q <= core_res;
    end
  end

  assign res_o.valid           = out_valid_q;
  assign res_o.kind            = out_q.kind;
  assign res_o.data_byte       = out_q.data_byte;
  assign res_o.frame_status    = out_q.frame_status;
  assign res_o.api_id          = out_q.api_id;
  assign res_o.source_address  = out_q.source_address;
  assign res_o.signal_strength = out_q.signal_strength;
  assign res_o.rx_options      = out_q.rx_options;
  assign res_o.tx_frame_id     = out_q.tx_frame_id;
  assign res_o.tx_status       = out_q.tx_status;
  assign res_o.data_count      = out_q.data_count;

endmodule

`default_nettype wire

// ----- design/eafr_core.sv -----
// line and frame parser state with its per-byte update
`default_nettype none

module eafr_core
  import eafr_pkg::*;
#(
  parameter int unsigned LINE_CHARS    = 30,
  parameter int unsigned MAX_FRAME_LEN = 126
) (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         step_i,
  input  wire logic [7:0]   rx_byte_i,
  input  wire logic         line_mode_i,
  output eafr_result_t      res_o,
  output logic              res_valid_o
);

  localparam logic [5:0]  LineLimit = 6'(LINE_CHARS);
  localparam logic [15:0] MaxLen    = 16'(MAX_FRAME_LEN);

  logic [4:0]       line_count_q, line_count_d;
  eafr_phase_e      phase_q, phase_d;
  logic             esc_q, esc_d;
  logic [LEN_W-1:0] byte_count_q, byte_count_d;
  logic [7:0]       len_hi_q, len_hi_d;
  logic [LEN_W-1:0] frame_len_q, frame_len_d;
  logic [7:0]       sum_q, sum_d;
  logic [7:0]       api_q, api_d;
  logic [15:0]      addr_q, addr_d;
  logic [7:0]       rssi_q, rssi_d;
  logic [7:0]       opt_q, opt_d;
  logic [7:0]       fid_q, fid_d;
  logic [7:0]       txs_q, txs_d;

  logic [7:0]       ub;
  logic [15:0]      full_len;
  logic [7:0]       sum_next;
  logic [LEN_W-1:0] count_next;

  assign ub         = esc_q ? (rx_byte_i ^ ESC_XOR) : rx_byte_i;
  assign full_len   = {len_hi_q, ub};
  assign sum_next   = sum_q + ub;
  assign count_next = byte_count_q + LEN_W'(1);

  always_comb begin
    line_count_d = line_count_q;
    phase_d      = phase_q;
    esc_d        = esc_q;
    byte_count_d = byte_count_q;
    len_hi_d     = len_hi_q;
    frame_len_d  = frame_len_q;
    sum_d        = sum_q;
    api_d        = api_q;
    addr_d       = addr_q;
    rssi_d       = rssi_q;
    opt_d        = opt_q;
    fid_d        = fid_q;
    txs_d        = txs_q;
    res_o        = '0;
    res_valid_o  = 1'b0;

    if (line_mode_i) begin
      res_valid_o = 1'b1;
      if (rx_byte_i == CR_BYTE || ({1'b0, line_count_q} + 6'd1) >= LineLimit) begin
        res_o.kind       = KIND_LINE_END;
        res_o.data_count = LEN_W'(line_count_q);
        line_count_d     = '0;
      end else begin
        res_o.kind      = KIND_CHAR;
        res_o.data_byte = rx_byte_i;
        line_count_d    = line_count_q + 5'd1;
      end
    end else if (phase_q == PH_HUNT) begin
      if (rx_byte_i == START_BYTE) begin
        phase_d      = PH_LEN;
        byte_count_d = '0;
        esc_d        = 1'b0;
      end
    end else if (rx_byte_i == ESC_BYTE && !esc_q) begin
      esc_d = 1'b1;
    end else begin
      esc_d = 1'b0;
      unique case (phase_q)
        PH_LEN: begin
          if (byte_count_q == '0) begin
            len_hi_d     = ub;
            byte_count_d = LEN_W'(1);
          end else if (full_len == 16'd0 || full_len > MaxLen) begin
            phase_d      = PH_HUNT;
            byte_count_d = '0;
            frame_len_d  = '0;
          end else begin
            phase_d      = PH_PAY;
            frame_len_d  = full_len[LEN_W-1:0];
            byte_count_d = '0;
            sum_d        = '0;
            api_d        = '0;
            addr_d       = '0;
            rssi_d       = '0;
            opt_d        = '0;
            fid_d        = '0;
            txs_d        = '0;
          end
        end
        PH_PAY: begin
          sum_d        = sum_next;
          byte_count_d = count_next;
          if (count_next >= frame_len_q) begin
            phase_d = PH_SUM;
          end
          if (byte_count_q == '0) begin
            api_d = ub;
          end else if (api_q == API_RX16) begin
            case (byte_count_q)
              LEN_W'(1): addr_d = {ub, 8'h00};
              LEN_W'(2): addr_d = {addr_q[15:8], ub};
              LEN_W'(3): rssi_d = ub;
              LEN_W'(4): opt_d  = ub;
              default: begin
                res_valid_o     = 1'b1;
                res_o.kind      = KIND_DATA;
                res_o.data_byte = ub;
              end
            endcase
          end else if (api_q == API_TXSTAT) begin
            if (byte_count_q == LEN_W'(1)) begin
              fid_d = ub;
            end else if (byte_count_q == LEN_W'(2)) begin
              txs_d = ub;
            end
          end
        end
        PH_SUM: begin
          sum_d                 = sum_next;
          res_valid_o           = 1'b1;
          res_o.kind            = KIND_FRAME_END;
          res_o.api_id          = api_q;
          res_o.source_address  = addr_q;
          res_o.signal_strength = rssi_q;
          res_o.rx_options      = opt_q;
          res_o.tx_frame_id     = fid_q;
          res_o.tx_status       = txs_q;
          if (sum_next != SUM_OK) begin
            res_o.frame_status = STAT_BAD_SUM;
          end else if (api_q == API_RX16 || api_q == API_TXSTAT) begin
            res_o.frame_status = STAT_OK;
          end else begin
            res_o.frame_status = STAT_BAD_API;
          end
          if (api_q == API_RX16 && frame_len_q > RX_HDR_LEN) begin
            res_o.data_count = frame_len_q - RX_HDR_LEN;
          end
          phase_d      = PH_HUNT;
          frame_len_d  = '0;
          byte_count_d = '0;
        end
        default: begin
          phase_d = PH_HUNT;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      line_count_q <= '0;
      phase_q      <= PH_HUNT;
      esc_q        <= 1'b0;
      byte_count_q <= '0;
      len_hi_q     <= '0;
      frame_len_q  <= '0;
      sum_q        <= '0;
      api_q        <= '0;
      addr_q       <= '0;
      rssi_q       <= '0;
      opt_q        <= '0;
      fid_q        <= '0;
      txs_q        <= '0;
    end else if (step_i) begin
      line_count_q <= line_count_d;
      phase_q      <= phase_d;
      esc_q        <= esc_d;
      byte_count_q <= byte_count_d;
      len_hi_q     <= len_hi_d;
      frame_len_q  <= frame_len_d;
      sum_q        <= sum_d;
      api_q        <= api_d;
      addr_q       <= addr_d;
      rssi_q       <= rssi_d;
      opt_q        <= opt_d;
      fid_q        <= fid_d;
      txs_q        <= txs_d;
    end
  end

endmodule

`default_nettype wire
